// ===== sv/pisht_pkg.sv =====
// ----------------------------------------------------------------------------
// pisht_pkg: shared types and constants of the point-in-shape hit test
// Coordinate widths, the shape codes and the classified item that the front
// end hands to the arithmetic back end through the queue.
// ----------------------------------------------------------------------------
package pisht_pkg;

  // Coordinate width; fraction bits do not matter since every test compares
  // quantities of the same scale.
  localparam int COORD_BITS = 16;

  localparam int CW  = COORD_BITS;      // coordinate
  localparam int EW  = COORD_BITS - 1;  // extent / radius (unsigned)
  localparam int DW  = COORD_BITS + 1;  // difference of two coordinates
  localparam int OW  = COORD_BITS + 2;  // corner offset (three terms)
  localparam int PW  = 2 * CW;          // coord x coord product
  localparam int PW1 = 2 * CW + 1;      // diff x coord product
  localparam int TW  = 2 * CW + 3;      // triangle edge sums and area
  localparam int UW  = DW + EW;         // |d| * extent
  localparam int U2W = 2 * UW;          // its square

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    SHAPE_CIRCLE   = 3'd0,
    SHAPE_ELLIPSE  = 3'd1,
    SHAPE_RECT     = 3'd2,
    SHAPE_ROUNDED  = 3'd3,
    SHAPE_TRIANGLE = 3'd4,
    SHAPE_NONE     = 3'd5
  } shape_e;

  // Classified item, as queued between front and back
  typedef struct packed {
    shape_e                 shape;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic        [EW-1:0]   ex;
    logic        [EW-1:0]   ey;
    logic        [EW-1:0]   rad;
    logic                   in_rect;
    logic signed [OW-1:0]   a1;   // cx - x1 - r
    logic signed [OW-1:0]   b1;   // cy - y1 - r
    logic signed [OW-1:0]   a2;   // x1 + w - r - cx
    logic signed [OW-1:0]   b2;   // y1 + h - r - cy
    logic signed [CW-1:0]   cx;
    logic signed [CW-1:0]   cy;
    logic signed [CW-1:0]   x1;
    logic signed [CW-1:0]   y1;
    logic signed [CW-1:0]   x2;
    logic signed [CW-1:0]   y2;
    logic signed [CW-1:0]   x3;
    logic signed [CW-1:0]   y3;
    logic signed [DW-1:0]   d31y; // y3 - y1
    logic signed [DW-1:0]   d13x; // x1 - x3
    logic signed [DW-1:0]   d12y; // y1 - y2
    logic signed [DW-1:0]   d21x; // x2 - x1
    logic signed [DW-1:0]   d32x; // x3 - x2
    logic signed [DW-1:0]   d23y; // y2 - y3
  } hit_item_t;

  // Queue handshake toward the back end
  typedef struct packed {
    logic      valid;
    hit_item_t item;
  } queue_out_t;

endpackage

// ===== sv/pisht_front.sv =====
// ----------------------------------------------------------------------------
// pisht_front: input acceptance and classification
// Decodes the mode, forms coordinate differences, rectangle bounds and corner
// offsets, and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module pisht_front import pisht_pkg::*; (
  input  logic                 in_valid_i,
  input  logic                 q_full_i,
  input  logic [2:0]           mode_i,
  input  logic signed [CW-1:0] cursor_x_i,
  input  logic signed [CW-1:0] cursor_y_i,
  input  logic signed [CW-1:0] ref_x_i,
  input  logic signed [CW-1:0] ref_y_i,
  input  logic signed [CW-1:0] second_x_i,
  input  logic signed [CW-1:0] second_y_i,
  input  logic signed [CW-1:0] third_x_i,
  input  logic signed [CW-1:0] third_y_i,
  input  logic [EW-1:0]        extent_x_i,
  input  logic [EW-1:0]        extent_y_i,
  input  logic [EW-1:0]        radius_i,
  output logic                 in_stall_o,
  output logic                 push_o,
  output hit_item_t            item_o
);

  logic signed [OW-1:0] cx_w, cy_w, x1_w, y1_w, w_w, h_w, r_w;
  logic signed [OW-1:0] right_w, bottom_w;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign cx_w = OW'(cursor_x_i);
  assign cy_w = OW'(cursor_y_i);
  assign x1_w = OW'(ref_x_i);
  assign y1_w = OW'(ref_y_i);
  assign w_w  = $signed({3'b000, extent_x_i});
  assign h_w  = $signed({3'b000, extent_y_i});
  assign r_w  = $signed({3'b000, radius_i});

  assign right_w  = x1_w + w_w;
  assign bottom_w = y1_w + h_w;

  always_comb begin
    case (mode_i)
      SHAPE_CIRCLE:   item_o.shape = SHAPE_CIRCLE;
      SHAPE_ELLIPSE:  item_o.shape = SHAPE_ELLIPSE;
      SHAPE_RECT:     item_o.shape = SHAPE_RECT;
      SHAPE_ROUNDED:  item_o.shape = SHAPE_ROUNDED;
      SHAPE_TRIANGLE: item_o.shape = SHAPE_TRIANGLE;
      default:        item_o.shape = SHAPE_NONE;
    endcase
    item_o.dx      = DW'(cursor_x_i) - DW'(ref_x_i);
    item_o.dy      = DW'(cursor_y_i) - DW'(ref_y_i);
    item_o.ex      = extent_x_i;
    item_o.ey      = extent_y_i;
    item_o.rad     = radius_i;
    // bounds inclusive
    item_o.in_rect = (cx_w >= x1_w) && (cy_w >= y1_w) &&
                     (cx_w <= right_w) && (cy_w <= bottom_w);
    item_o.a1      = cx_w - x1_w - r_w;
    item_o.b1      = cy_w - y1_w - r_w;
    item_o.a2      = right_w - r_w - cx_w;
    item_o.b2      = bottom_w - r_w - cy_w;
    item_o.cx      = cursor_x_i;
    item_o.cy      = cursor_y_i;
    item_o.x1      = ref_x_i;
    item_o.y1      = ref_y_i;
    item_o.x2      = second_x_i;
    item_o.y2      = second_y_i;
    item_o.x3      = third_x_i;
    item_o.y3      = third_y_i;
    item_o.d31y    = DW'(third_y_i)  - DW'(ref_y_i);
    item_o.d13x    = DW'(ref_x_i)    - DW'(third_x_i);
    item_o.d12y    = DW'(ref_y_i)    - DW'(second_y_i);
    item_o.d21x    = DW'(second_x_i) - DW'(ref_x_i);
    item_o.d32x    = DW'(third_x_i)  - DW'(second_x_i);
    item_o.d23y    = DW'(second_y_i) - DW'(third_y_i);
  end

endmodule

// ===== sv/pisht_queue.sv =====
// ----------------------------------------------------------------------------
// pisht_queue: short item queue between front and back
// Flip-flop FIFO of QDEPTH classified items.
// ----------------------------------------------------------------------------
module pisht_queue import pisht_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hit_item_t  item_i,
  output logic       full_o,
  input  logic       pop_i,
  output queue_out_t head_o
);

  hit_item_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_pop;

  assign full_o      = (cnt_q == QCNT_W'(QDEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_q];
  assign do_pop      = pop_i && head_o.valid;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== sv/pisht_back.sv =====
// ----------------------------------------------------------------------------
// pisht_back: arithmetic back end
// Three register stages: products, sums and squares, final compares. The last
// stage is the output register; all stages advance together.
// ----------------------------------------------------------------------------
module pisht_back import pisht_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  queue_out_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       inside_res_o
);

  logic adv;
  assign adv   = !out_valid_o || !out_stall_i;
  assign pop_o = adv;

  hit_item_t it;
  assign it = head_i.item;

  // ---------------- stage 1: products ----------------
  logic [DW-1:0] mdx, mdy;
  logic [OW-1:0] ma1, mb1, ma2, mb2;

  assign mdx = it.dx[DW-1] ? DW'(-it.dx) : DW'(it.dx);
  assign mdy = it.dy[DW-1] ? DW'(-it.dy) : DW'(it.dy);
  assign ma1 = it.a1[OW-1] ? OW'(-it.a1) : OW'(it.a1);
  assign mb1 = it.b1[OW-1] ? OW'(-it.b1) : OW'(it.b1);
  assign ma2 = it.a2[OW-1] ? OW'(-it.a2) : OW'(it.a2);
  assign mb2 = it.b2[OW-1] ? OW'(-it.b2) : OW'(it.b2);

  logic                  v1_q;
  shape_e                shape1_q;
  logic [2*DW-1:0]       sdx_q, sdy_q;
  logic [2*EW-1:0]       r2_q;
  logic [UW-1:0]         eu_q, ev_q;
  logic [2*EW-1:0]       ew_q;
  logic                  ezero1_q;
  logic                  in_rect1_q;
  logic [2*OW-1:0]       sa1_q, sb1_q, sa2_q, sb2_q;
  logic [3:0]            cneg_q;
  logic signed [PW-1:0]  p1_q, p2_q, q1_q, q2_q, m1_q, m4_q;
  logic signed [PW1-1:0] p3_q, p4_q, q3_q, q4_q, m2_q, m3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= head_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      shape1_q   <= it.shape;
      sdx_q      <= mdx * mdx;
      sdy_q      <= mdy * mdy;
      r2_q       <= it.rad * it.rad;
      eu_q       <= mdx * it.ey;
      ev_q       <= mdy * it.ex;
      ew_q       <= it.ex * it.ey;
      ezero1_q   <= (it.ex == '0) || (it.ey == '0);
      in_rect1_q <= it.in_rect;
      sa1_q      <= ma1 * ma1;
      sb1_q      <= mb1 * mb1;
      sa2_q      <= ma2 * ma2;
      sb2_q      <= mb2 * mb2;
      // corners: top-left, bottom-left, bottom-right, top-right
      cneg_q     <= {it.a2[OW-1] && it.b1[OW-1], it.a2[OW-1] && it.b2[OW-1],
                     it.a1[OW-1] && it.b2[OW-1], it.a1[OW-1] && it.b1[OW-1]};
      p1_q       <= it.y1 * it.x3;
      p2_q       <= it.x1 * it.y3;
      p3_q       <= it.d31y * it.cx;
      p4_q       <= it.d13x * it.cy;
      q1_q       <= it.x1 * it.y2;
      q2_q       <= it.y1 * it.x2;
      q3_q       <= it.d12y * it.cx;
      q4_q       <= it.d21x * it.cy;
      m1_q       <= it.y2 * it.x3;
      m2_q       <= it.y1 * it.d32x;
      m3_q       <= it.x1 * it.d23y;
      m4_q       <= it.x2 * it.y3;
    end
  end

  // ---------------- stage 2: sums, squares ----------------
  logic              circ_hit, round_hit;
  logic [3:0]        cut;
  logic              hit_pre;

  assign circ_hit = ({1'b0, sdx_q} + {1'b0, sdy_q}) <= (2*DW+1)'(r2_q);
  assign cut[0]   = cneg_q[0] && (({1'b0, sa1_q} + {1'b0, sb1_q}) > (2*OW+1)'(r2_q));
  assign cut[1]   = cneg_q[1] && (({1'b0, sa1_q} + {1'b0, sb2_q}) > (2*OW+1)'(r2_q));
  assign cut[2]   = cneg_q[2] && (({1'b0, sa2_q} + {1'b0, sb2_q}) > (2*OW+1)'(r2_q));
  assign cut[3]   = cneg_q[3] && (({1'b0, sa2_q} + {1'b0, sb1_q}) > (2*OW+1)'(r2_q));
  assign round_hit = in_rect1_q && !(|cut);

  always_comb begin
    case (shape1_q)
      SHAPE_CIRCLE:  hit_pre = circ_hit;
      SHAPE_RECT:    hit_pre = in_rect1_q;
      SHAPE_ROUNDED: hit_pre = round_hit;
      default:       hit_pre = 1'b0;
    endcase
  end

  logic                 v2_q;
  shape_e               shape2_q;
  logic                 hit2_q;
  logic                 ezero2_q;
  logic [U2W-1:0]       eu2_q, ev2_q;
  logic [4*EW-1:0]      ew2_q;
  logic signed [TW-1:0] s_q, t_q, a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      shape2_q <= shape1_q;
      hit2_q   <= hit_pre;
      ezero2_q <= ezero1_q;
      eu2_q    <= eu_q * eu_q;
      ev2_q    <= ev_q * ev_q;
      ew2_q    <= ew_q * ew_q;
      s_q      <= TW'(p1_q) - TW'(p2_q) + TW'(p3_q) + TW'(p4_q);
      t_q      <= TW'(q1_q) - TW'(q2_q) + TW'(q3_q) + TW'(q4_q);
      a_q      <= TW'(m2_q) - TW'(m1_q) + TW'(m3_q) + TW'(m4_q);
    end
  end

  // ---------------- stage 3: final compares, output register ----------------
  logic                 ell_hit, tri_hit, hit_fin;
  logic signed [TW-1:0] sp, tp, ap;
  logic signed [TW:0]   st_sum;

  assign ell_hit = !ezero2_q && (({1'b0, eu2_q} + {1'b0, ev2_q}) <= (U2W+1)'(ew2_q));

  // orient by the sign of the doubled area
  assign sp     = a_q[TW-1] ? -s_q : s_q;
  assign tp     = a_q[TW-1] ? -t_q : t_q;
  assign ap     = a_q[TW-1] ? -a_q : a_q;
  assign st_sum = (TW+1)'(sp) + (TW+1)'(tp);
  assign tri_hit = (s_q[TW-1] == t_q[TW-1]) &&
                   !sp[TW-1] && (sp != '0) && !tp[TW-1] && (tp != '0) &&
                   (st_sum < (TW+1)'(ap));

  always_comb begin
    case (shape2_q)
      SHAPE_ELLIPSE:  hit_fin = ell_hit;
      SHAPE_TRIANGLE: hit_fin = tri_hit;
      default:        hit_fin = hit2_q;
    endcase
  end

  logic v3_q, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= hit_fin;
    end
  end

  assign out_valid_o  = v3_q;
  assign inside_res_o = res_q;

endmodule

// ===== sv/point_in_shape_hit_test.sv =====
// ----------------------------------------------------------------------------
// point_in_shape_hit_test: cursor point against one shape per item
// Circle, ellipse, rectangle, rounded rectangle and triangle hit testing on
// signed fixed-point coordinates, with exact integer arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with the shape fields. An item is
//   taken at a rising edge with in_valid_i high and in_stall_o low.
//   Output channel: out_valid_o / out_stall_i with inside_res_o; one result
//   per item, in order, taken when out_valid_o is high and out_stall_i low.
//   Path: queue write, product stage, sum/square stage, output register.
//   Throughput: one item per cycle unless the output stalls; the back end
//   runs three register stages deep with at most one 32x32 multiply
//   between registers.
//   Stall: a stalled result holds in the output register and freezes the
//   back end; the front keeps taking items into a 4-entry queue and raises
//   in_stall_o only when the queue is full.
//   Reset: rst_ni clears the queue and every stage valid; no result is
//   pending afterward. There is no configuration and no state between items.
//   Modes 5 to 7 answer 0.
// ----------------------------------------------------------------------------
module point_in_shape_hit_test import pisht_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           mode_i,
  input  logic signed [CW-1:0] cursor_x_i,
  input  logic signed [CW-1:0] cursor_y_i,
  input  logic signed [CW-1:0] ref_x_i,
  input  logic signed [CW-1:0] ref_y_i,
  input  logic signed [CW-1:0] second_x_i,
  input  logic signed [CW-1:0] second_y_i,
  input  logic signed [CW-1:0] third_x_i,
  input  logic signed [CW-1:0] third_y_i,
  input  logic [EW-1:0]        extent_x_i,
  input  logic [EW-1:0]        extent_y_i,
  input  logic [EW-1:0]        radius_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 inside_res_o
);

  // front -> queue
  logic       push;
  logic       q_full;
  hit_item_t  item;
  // queue -> back
  queue_out_t head;
  logic       pop;

  // Front: classifies the mode and forms differences and bounds
  pisht_front u_front (
    .in_valid_i (in_valid_i),
    .q_full_i   (q_full),
    .mode_i     (mode_i),
    .cursor_x_i (cursor_x_i),
    .cursor_y_i (cursor_y_i),
    .ref_x_i    (ref_x_i),
    .ref_y_i    (ref_y_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .third_x_i  (third_x_i),
    .third_y_i  (third_y_i),
    .extent_x_i (extent_x_i),
    .extent_y_i (extent_y_i),
    .radius_i   (radius_i),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .item_o     (item)
  );

  // Queue decouples the front from back-end stalls
  pisht_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  // Back: multiply, sum and compare, ending in the output register
  pisht_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .inside_res_o (inside_res_o)
  );

endmodule

// ===== bench/hit_test_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hit_test_checker: result scoreboard for the point-in-shape hit test
// Watches both channels. For each item taken it works out the inside/outside
// answer with wide integer math and queues it. Each result taken must match
// the oldest queued answer.
// ----------------------------------------------------------------------------
module hit_test_checker import pisht_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [2:0]           mode_i,
  input  logic signed [CW-1:0] cursor_x_i,
  input  logic signed [CW-1:0] cursor_y_i,
  input  logic signed [CW-1:0] ref_x_i,
  input  logic signed [CW-1:0] ref_y_i,
  input  logic signed [CW-1:0] second_x_i,
  input  logic signed [CW-1:0] second_y_i,
  input  logic signed [CW-1:0] third_x_i,
  input  logic signed [CW-1:0] third_y_i,
  input  logic [EW-1:0]        extent_x_i,
  input  logic [EW-1:0]        extent_y_i,
  input  logic [EW-1:0]        radius_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 inside_res_i,
  output int                   pending_o,
  output int                   mismatches_o
);

  localparam int REPORT_MAX = 10;

  typedef struct {
    logic        in_shape;
    logic [2:0]  mode;
    int unsigned idx;
  } hit_expect_t;

  hit_expect_t expected_hits[$];
  int unsigned item_idx;

  function automatic longint sqr(input longint v);
    return v * v;
  endfunction

  // corner square: both offsets negative and past the arc
  function automatic bit corner_cut(input longint a, input longint b, input longint r);
    return (a < 0) && (b < 0) && (sqr(a) + sqr(b) > sqr(r));
  endfunction

  function automatic bit shape_contains(
    input logic [2:0] mode,
    input longint cx, input longint cy,
    input longint x1, input longint y1,
    input longint x2, input longint y2,
    input longint x3, input longint y3,
    input longint ex, input longint ey, input longint r
  );
    longint       dx, dy, s, t, a;
    logic [127:0] lhs, rhs;
    bit           in_box, hit;
    dx     = cx - x1;
    dy     = cy - y1;
    in_box = (cx >= x1) && (cy >= y1) && (cx <= x1 + ex) && (cy <= y1 + ey);
    hit    = 1'b0;
    case (mode)
      SHAPE_CIRCLE: begin
        hit = (sqr(dx) + sqr(dy)) <= sqr(r);
      end
      SHAPE_ELLIPSE: begin
        if (ex != 0 && ey != 0) begin
          lhs = {64'd0, sqr(dx)} * {64'd0, sqr(ey)} + {64'd0, sqr(dy)} * {64'd0, sqr(ex)};
          rhs = {64'd0, sqr(ex)} * {64'd0, sqr(ey)};
          hit = lhs <= rhs;
        end
      end
      SHAPE_RECT: begin
        hit = in_box;
      end
      SHAPE_ROUNDED: begin
        hit = in_box
              && !corner_cut(cx - x1 - r, cy - y1 - r, r)
              && !corner_cut(cx - x1 - r, y1 + ey - r - cy, r)
              && !corner_cut(x1 + ex - r - cx, y1 + ey - r - cy, r)
              && !corner_cut(x1 + ex - r - cx, cy - y1 - r, r);
      end
      SHAPE_TRIANGLE: begin
        s = y1 * x3 - x1 * y3 + (y3 - y1) * cx + (x1 - x3) * cy;
        t = x1 * y2 - y1 * x2 + (y1 - y2) * cx + (x2 - x1) * cy;
        if ((s < 0) == (t < 0)) begin
          a = -y2 * x3 + y1 * (x3 - x2) + x1 * (y2 - y3) + x2 * y3;
          if (a < 0) begin
            s = -s;
            t = -t;
            a = -a;
          end
          hit = (s > 0) && (t > 0) && ((s + t) < a);
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    return hit;
  endfunction

  initial begin
    pending_o    = 0;
    mismatches_o = 0;
    item_idx     = 0;
  end

  always @(posedge clk_i) begin : scoreboard
    hit_expect_t head, fresh;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_hits.size() == 0) begin
          mismatches_o = mismatches_o + 1;
          if (mismatches_o <= REPORT_MAX)
            $display("%0t: result %0b with no item outstanding", $realtime, inside_res_i);
        end else begin
          head = expected_hits.pop_front();
          if (inside_res_i !== head.in_shape) begin
            mismatches_o = mismatches_o + 1;
            if (mismatches_o <= REPORT_MAX)
              $display("%0t: item %0d mode %0d: inside_res expected %0b, got %0b",
                       $realtime, head.idx, head.mode, head.in_shape, inside_res_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        fresh.in_shape = shape_contains(mode_i,
                                        longint'(cursor_x_i), longint'(cursor_y_i),
                                        longint'(ref_x_i), longint'(ref_y_i),
                                        longint'(second_x_i), longint'(second_y_i),
                                        longint'(third_x_i), longint'(third_y_i),
                                        longint'(extent_x_i), longint'(extent_y_i),
                                        longint'(radius_i));
        fresh.mode     = mode_i;
        fresh.idx      = item_idx;
        item_idx       = item_idx + 1;
        expected_hits.push_back(fresh);
      end
      pending_o = expected_hits.size();
    end
  end

endmodule

// ===== bench/tb_point_in_shape_hit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_in_shape_hit_test: stimulus and verdict for the hit test block
// Directed corner cases for every shape, then random shapes with the cursor
// placed near each shape, plus full-range noise. Three idle profiles, one
// long output hold-off to back the block up. A separate checker scores.
// ----------------------------------------------------------------------------
module tb_point_in_shape_hit_test;
  import pisht_pkg::*;

  localparam int RANDOM_PER_PHASE = 525;
  localparam int WATCHDOG_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES     = 10;    // idle margin after the last result
  localparam int HOLD_CYCLES      = 80;    // long output hold-off
  localparam int MODE_LAST        = 7;     // highest value the mode field holds

  // One item as offered on the input channel
  typedef struct {
    logic [2:0]           mode;
    logic signed [CW-1:0] cx, cy, x1, y1, x2, y2, x3, y3;
    logic [EW-1:0]        ex, ey, rad;
  } shape_item_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [2:0]           mode;
  logic signed [CW-1:0] cursor_x, cursor_y, ref_x, ref_y;
  logic signed [CW-1:0] second_x, second_y, third_x, third_y;
  logic [EW-1:0]        extent_x, extent_y, radius;
  logic                 out_valid;
  logic                 out_stall;
  logic                 inside_res;

  int pending_hits;
  int mismatches;
  int send_idle_pct;   // chance per cycle that the sender sits idle
  int recv_idle_pct;   // chance per cycle that the receiver stalls
  bit hold_req;        // asks the receiver for one long hold-off
  int hold_left;
  int quiet_cycles;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  point_in_shape_hit_test dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .mode_i      (mode),
    .cursor_x_i  (cursor_x),
    .cursor_y_i  (cursor_y),
    .ref_x_i     (ref_x),
    .ref_y_i     (ref_y),
    .second_x_i  (second_x),
    .second_y_i  (second_y),
    .third_x_i   (third_x),
    .third_y_i   (third_y),
    .extent_x_i  (extent_x),
    .extent_y_i  (extent_y),
    .radius_i    (radius),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .inside_res_o(inside_res)
  );

  hit_test_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .mode_i      (mode),
    .cursor_x_i  (cursor_x),
    .cursor_y_i  (cursor_y),
    .ref_x_i     (ref_x),
    .ref_y_i     (ref_y),
    .second_x_i  (second_x),
    .second_y_i  (second_y),
    .third_x_i   (third_x),
    .third_y_i   (third_y),
    .extent_x_i  (extent_x),
    .extent_y_i  (extent_y),
    .radius_i    (radius),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .inside_res_i(inside_res),
    .pending_o   (pending_hits),
    .mismatches_o(mismatches)
  );

  // Symmetric random offset in [-span, span]
  function automatic int jitter(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Offer one item: optional idle cycles first, then hold valid and the
  // payload steady until the block takes it. Starts and ends at a falling edge.
  task automatic drive_item(input shape_item_t it);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= it.mode;
    cursor_x <= it.cx;
    cursor_y <= it.cy;
    ref_x    <= it.x1;
    ref_y    <= it.y1;
    second_x <= it.x2;
    second_y <= it.y2;
    third_x  <= it.x3;
    third_y  <= it.y3;
    extent_x <= it.ex;
    extent_y <= it.ey;
    radius   <= it.rad;
    do
      @(posedge clk);
    while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_shape(input int m, input int cx, input int cy,
                            input int x1, input int y1, input int x2, input int y2,
                            input int x3, input int y3,
                            input int ex, input int ey, input int rad);
    shape_item_t it;
    it.mode = 3'(m);
    it.cx = CW'(cx);  it.cy = CW'(cy);
    it.x1 = CW'(x1);  it.y1 = CW'(y1);
    it.x2 = CW'(x2);  it.y2 = CW'(y2);
    it.x3 = CW'(x3);  it.y3 = CW'(y3);
    it.ex = EW'(ex);  it.ey = EW'(ey);
    it.rad = EW'(rad);
    drive_item(it);
  endtask

  // Mostly a valid shape with the cursor around its boundary; some items are
  // raw full-range noise, which also covers the unused mode codes.
  task automatic make_random_item(output shape_item_t it);
    int span, bx, by, ext_x, ext_y, rad, px, py, ux, uy, vx, vy;
    it.mode = 3'($urandom_range(MODE_LAST));
    it.cx = CW'($urandom);  it.cy = CW'($urandom);
    it.x1 = CW'($urandom);  it.y1 = CW'($urandom);
    it.x2 = CW'($urandom);  it.y2 = CW'($urandom);
    it.x3 = CW'($urandom);  it.y3 = CW'($urandom);
    it.ex = EW'($urandom);  it.ey = EW'($urandom);
    it.rad = EW'($urandom);
    if ($urandom_range(99) >= 15) begin
      it.mode = 3'($urandom_range(int'(SHAPE_TRIANGLE)));
      // small shapes dominate, a few span the whole range
      case ($urandom_range(9))
        0:       span = 32767;
        1, 2, 3: span = 1023;
        default: span = 63;
      endcase
      ext_x = $urandom_range(span);
      ext_y = $urandom_range(span);
      rad   = $urandom_range(span);
      bx    = jitter(20000);
      by    = jitter(20000);
      case (it.mode)
        SHAPE_CIRCLE: begin
          px = jitter(rad + 2);
          py = jitter(rad + 2);
        end
        SHAPE_ELLIPSE: begin
          if ($urandom_range(15) == 0) ext_x = 0;
          if ($urandom_range(15) == 0) ext_y = 0;
          px = jitter(ext_x + 2);
          py = jitter(ext_y + 2);
        end
        SHAPE_RECT, SHAPE_ROUNDED: begin
          px = int'($urandom_range(ext_x + 4)) - 2;
          py = int'($urandom_range(ext_y + 4)) - 2;
          // land exactly on an edge now and then
          if ($urandom_range(3) == 0) px = $urandom_range(1) ? ext_x : 0;
          if ($urandom_range(3) == 0) py = $urandom_range(1) ? ext_y : 0;
          if ($urandom_range(7) == 0)
            rad = $urandom_range(32767);
          else
            rad = $urandom_range(((ext_x > ext_y) ? ext_x : ext_y) / 2 + 2);
        end
        default: begin  // triangle
          ux = bx + jitter(span);
          uy = by + jitter(span);
          vx = bx + jitter(span);
          vy = by + jitter(span);
          if ($urandom_range(7) == 0) begin
            // collinear vertices, zero area
            vx = 2 * ux - bx;
            vy = 2 * uy - by;
          end
          it.x2 = CW'(ux);  it.y2 = CW'(uy);
          it.x3 = CW'(vx);  it.y3 = CW'(vy);
          px = jitter(span);
          py = jitter(span);
          if ($urandom_range(7) == 0) begin
            // midpoint of the first edge: on the edge when the sums are even
            px = (ux - bx) / 2;
            py = (uy - by) / 2;
          end
        end
      endcase
      it.x1  = CW'(bx);
      it.y1  = CW'(by);
      it.cx  = CW'(bx + px);
      it.cy  = CW'(by + py);
      it.ex  = EW'(ext_x);
      it.ey  = EW'(ext_y);
      it.rad = EW'(rad);
    end
  endtask

  task automatic run_random(input int count);
    shape_item_t it;
    repeat (count) begin
      make_random_item(it);
      drive_item(it);
    end
  endtask

  // Receiver: random stalls, or one long hold-off on request so that the
  // internal queue fills and the block pushes back on its input.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (int'($urandom_range(99)) < recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any handshake means the block is stuck
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("point_in_shape_hit_test: mismatch");
      $finish;
    end
  end

  initial begin
    // every input known from time zero
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    hold_req      = 1'b0;
    mode          = SHAPE_CIRCLE;
    cursor_x      = '0;
    cursor_y      = '0;
    ref_x         = '0;
    ref_y         = '0;
    second_x      = '0;
    second_y      = '0;
    third_x       = '0;
    third_y       = '0;
    extent_x      = '0;
    extent_y      = '0;
    radius        = '0;
    send_idle_pct = 6;
    recv_idle_pct = 50;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed: extremes and special cases, per shape ----
    // args: mode, cursor, ref, second, third, extent x/y, radius
    // circle: zero radius on its center, point on the rim, full-range offsets
    send_shape(SHAPE_CIRCLE, 100, -40, 100, -40, 0, 0, 0, 0, 0, 0, 0);
    send_shape(SHAPE_CIRCLE, 3, 4, 0, 0, 0, 0, 0, 0, 0, 0, 5);
    send_shape(SHAPE_CIRCLE, 32767, 32767, -32768, -32768, 0, 0, 0, 0, 0, 0, 32767);
    send_shape(SHAPE_CIRCLE, -32768, 0, 0, 0, 0, 0, 0, 0, 32767, 32767, 32767);
    // ellipse: either radius zero reports outside even on the center
    send_shape(SHAPE_ELLIPSE, 5, 5, 5, 5, 0, 0, 0, 0, 0, 10, 0);
    send_shape(SHAPE_ELLIPSE, 5, 5, 5, 5, 0, 0, 0, 0, 10, 0, 0);
    send_shape(SHAPE_ELLIPSE, 5, 0, 0, 0, 0, 0, 0, 0, 5, 3, 0);
    send_shape(SHAPE_ELLIPSE, 32767, -32768, -32768, 32767, 0, 0, 0, 0, 32767, 32767, 0);
    send_shape(SHAPE_ELLIPSE, 20000, 0, 0, 0, 0, 0, 0, 0, 32767, 1, 0);
    // rectangle: far edge sum must not wrap, zero size, one past the edge
    send_shape(SHAPE_RECT, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 32767, 32767, 0);
    send_shape(SHAPE_RECT, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0, 0);
    send_shape(SHAPE_RECT, 101, 50, 0, 0, 0, 0, 0, 0, 100, 100, 0);
    send_shape(SHAPE_RECT, 32767, 32767, -32768, -32768, 0, 0, 0, 0, 32767, 32767, 0);
    // rounded: cut corner, straight edge, radius wider than the box
    send_shape(SHAPE_ROUNDED, 0, 0, 0, 0, 0, 0, 0, 0, 100, 100, 20);
    send_shape(SHAPE_ROUNDED, 100, 50, 0, 0, 0, 0, 0, 0, 100, 100, 20);
    send_shape(SHAPE_ROUNDED, 5, 5, 0, 0, 0, 0, 0, 0, 10, 10, 32767);
    send_shape(SHAPE_ROUNDED, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 32767, 32767, 32767);
    send_shape(SHAPE_ROUNDED, 6, 6, 0, 0, 0, 0, 0, 0, 100, 100, 20);
    // triangle: inside, on an edge, both windings, zero area, full range
    send_shape(SHAPE_TRIANGLE, 10, 10, 0, 0, 100, 0, 0, 100, 0, 0, 0);
    send_shape(SHAPE_TRIANGLE, 50, 0, 0, 0, 100, 0, 0, 100, 0, 0, 0);
    send_shape(SHAPE_TRIANGLE, 10, 10, 0, 0, 0, 100, 100, 0, 0, 0, 0);
    send_shape(SHAPE_TRIANGLE, 5, 5, 0, 0, 10, 10, 20, 20, 0, 0, 0);
    send_shape(SHAPE_TRIANGLE, -32768, -32768, -32768, 32767, 32767, -32768,
               32767, 32767, 0, 0, 0);
    send_shape(SHAPE_TRIANGLE, 0, 0, -32768, -32768, 32767, -32768, 0, 32767, 0, 0, 0);
    // unused mode codes always answer outside
    for (int m = SHAPE_NONE; m <= MODE_LAST; m++)
      send_shape(m, 0, 0, 0, 0, 0, 0, 0, 0, 100, 100, 100);

    // ---- random, three idle profiles ----
    run_random(RANDOM_PER_PHASE);

    send_idle_pct = 50;
    recv_idle_pct = 6;
    run_random(RANDOM_PER_PHASE);

    // no idling; one long output hold-off while items keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    run_random(RANDOM_PER_PHASE);

    in_valid <= 1'b0;

    // drain; the watchdog covers a result that never shows up
    while (pending_hits != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0)
      $display("point_in_shape_hit_test: match");
    else
      $display("point_in_shape_hit_test: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pisht_pkg.sv
sv/pisht_front.sv
sv/pisht_queue.sv
sv/pisht_back.sv
sv/point_in_shape_hit_test.sv
bench/hit_test_checker.sv
bench/tb_point_in_shape_hit_test.sv
